// ===== rtl/core/sbrc_pkg.sv =====
// Shared widths, constants and payload types of the stereo barrel remap block.
package sbrc_pkg;

  // Field and fraction widths.
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int REG_W      = 13;
  localparam int CFG_AW     = 1;
  localparam int FILL_W     = 8;

  // Derived datapath widths.
  localparam int XCW = (COORD_BITS > REG_W) ? COORD_BITS : REG_W;
  localparam int DW  = XCW + 1;
  localparam int SQW = 2 * DW - 2;
  localparam int R2W = SQW + 1;
  localparam int MW  = 2 * REG_W + 1;
  localparam int QB  = FRAC_BITS + 3;
  localparam int QW  = QB;
  localparam int XW  = ((R2W - 1) > MW) ? (R2W - 1) : MW;
  localparam int Q2W = FRAC_BITS + 5;
  localparam int SW  = QW;
  localparam int PRW = DW + SW + 1;
  localparam int PBW = REG_W + FRAC_BITS + 1;
  localparam int PW  = ((PRW > PBW) ? PRW : PBW) + 1;
  localparam int NXW = PW - FRAC_BITS;

  // Fixed-point constants.
  localparam longint unsigned FX_HALF_I = 64'd1 << (FRAC_BITS - 1);
  localparam longint unsigned FX_C22_I  = ((64'd22 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam longint unsigned FX_C24_I  = ((64'd24 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [QW-1:0]        FX_ONE  = QW'(1) << FRAC_BITS;
  localparam logic [QW-1:0]        FX_QMAX = QW'(4) << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] FX_C22  = FRAC_BITS'(FX_C22_I);
  localparam logic [FRAC_BITS-1:0] FX_C24  = FRAC_BITS'(FX_C24_I);

  // Fill levels for pixels with no source.
  localparam logic [FILL_W-1:0] FILL_LUMA   = 8'd0;
  localparam logic [FILL_W-1:0] FILL_CHROMA = 8'd128;

  // Register indexes.
  localparam logic [CFG_AW-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;

  typedef struct packed {
    logic [COORD_BITS-1:0] dest_x;
    logic [COORD_BITS-1:0] dest_y;
    logic                  is_chroma;
  } sbrc_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] src_x;
    logic [COORD_BITS-1:0] src_y;
    logic                  valid_res;
    logic [FILL_W-1:0]     fill_value;
  } sbrc_out_t;

  // Per-pixel geometry that travels alongside the arithmetic.
  typedef struct packed {
    logic             ok;
    logic             chroma;
    logic [REG_W-1:0] xmid;
    logic [REG_W-1:0] ymid;
    logic [REG_W-1:0] start;
    logic [REG_W-1:0] stop;
    logic [REG_W-1:0] hgt;
    logic [DW-1:0]    dx;
    logic [DW-1:0]    dy;
  } sbrc_side_t;

endpackage

// ===== rtl/core/sbrc_geom.sv =====
// Front end: plane size, eye half, center, offsets, squared radius and diagonal.
module sbrc_geom (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  logic                      in_vld,
  input  sbrc_pkg::sbrc_in_t        in_data,
  input  logic [sbrc_pkg::REG_W-1:0] frame_w,
  input  logic [sbrc_pkg::REG_W-1:0] frame_h,
  output logic                      out_vld,
  output sbrc_pkg::sbrc_side_t      out_side,
  output logic [sbrc_pkg::R2W-1:0]  out_r2,
  output logic [sbrc_pkg::MW-1:0]   out_m4
);
  import sbrc_pkg::*;

  logic [REG_W-1:0]   w_c, h_c, half_c;
  logic [REG_W+1:0]   w3_c;
  logic [XCW-1:0]     x_e, y_e, w_e, h_e, half_e;
  logic               left_c;
  sbrc_side_t         s1_side_nxt;
  sbrc_side_t         s2_side_nxt;

  logic               s1_vld_r;
  sbrc_side_t         s1_side_r;
  logic [COORD_BITS-1:0] s1_x_r, s1_y_r;

  logic               s2_vld_r;
  sbrc_side_t         s2_side_r;
  logic [REG_W-1:0]   s2_span_r;

  logic signed [2*DW-1:0] dxx_c, dyy_c;
  logic [2*REG_W-1:0] ss_c, yy_c;

  logic               s3_vld_r;
  sbrc_side_t         s3_side_r;
  logic [SQW-1:0]     s3_dxx_r, s3_dyy_r;
  logic [2*REG_W-1:0] s3_ss_r, s3_yy_r;

  logic               s4_vld_r;
  sbrc_side_t         s4_side_r;
  logic [R2W-1:0]     s4_r2_r;
  logic [MW-1:0]      s4_m4_r;

  // Stage 1: plane size, eye half and its center.
  always_comb begin
    w_c    = in_data.is_chroma ? (frame_w >> 1) : frame_w;
    h_c    = in_data.is_chroma ? (frame_h >> 1) : frame_h;
    half_c = w_c >> 1;
    w3_c   = {2'b00, w_c} + {1'b0, w_c, 1'b0};
    x_e    = XCW'(in_data.dest_x);
    y_e    = XCW'(in_data.dest_y);
    w_e    = XCW'(w_c);
    h_e    = XCW'(h_c);
    half_e = XCW'(half_c);
    left_c = x_e < half_e;
    s1_side_nxt.ok     = (x_e < w_e) && (y_e < h_e);
    s1_side_nxt.chroma = in_data.is_chroma;
    s1_side_nxt.xmid   = left_c ? (w_c >> 2) : w3_c[REG_W+1:2];
    s1_side_nxt.ymid   = h_c >> 1;
    s1_side_nxt.start  = left_c ? '0 : half_c;
    s1_side_nxt.stop   = left_c ? half_c : w_c;
    s1_side_nxt.hgt    = h_c;
    s1_side_nxt.dx     = '0;
    s1_side_nxt.dy     = '0;
  end

  // Stage 2 geometry: signed offsets from the center.
  always_comb begin
    s2_side_nxt    = s1_side_r;
    s2_side_nxt.dx = $signed(DW'(s1_x_r)) - $signed(DW'(s1_side_r.xmid));
    s2_side_nxt.dy = $signed(DW'(s1_y_r)) - $signed(DW'(s1_side_r.ymid));
  end

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  // Stage 3 products.
  always_comb begin
    dxx_c = $signed(s2_side_r.dx) * $signed(s2_side_r.dx);
    dyy_c = $signed(s2_side_r.dy) * $signed(s2_side_r.dy);
    ss_c  = s2_span_r * s2_span_r;
    yy_c  = s2_side_r.ymid * s2_side_r.ymid;
  end

  // Payload of the four stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side_r <= s1_side_nxt;
      s1_x_r    <= in_data.dest_x;
      s1_y_r    <= in_data.dest_y;

      // Stage 2: signed offsets from the center and the half width.
      s2_side_r    <= s2_side_nxt;
      s2_span_r    <= s1_side_r.stop - s1_side_r.start;

      s3_side_r <= s2_side_r;
      s3_dxx_r  <= dxx_c[SQW-1:0];
      s3_dyy_r  <= dyy_c[SQW-1:0];
      s3_ss_r   <= ss_c;
      s3_yy_r   <= yy_c;

      // Stage 4: squared radius and four times the squared half-diagonal.
      s4_side_r <= s3_side_r;
      s4_r2_r   <= R2W'(s3_dxx_r) + R2W'(s3_dyy_r);
      s4_m4_r   <= MW'(s3_ss_r) + MW'({s3_yy_r, 2'b00});
    end
  end

  assign out_vld  = s4_vld_r;
  assign out_side = s4_side_r;
  assign out_r2   = s4_r2_r;
  assign out_m4   = s4_m4_r;

endmodule

// ===== rtl/core/sbrc_div.sv =====
// Pipelined restoring divider for the normalized squared radius, one quotient bit a stage.
module sbrc_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_vld,
  input  sbrc_pkg::sbrc_side_t     in_side,
  input  logic [sbrc_pkg::R2W-1:0] in_r2,
  input  logic [sbrc_pkg::MW-1:0]  in_m4,
  output logic                     out_vld,
  output sbrc_pkg::sbrc_side_t     out_side,
  output logic [sbrc_pkg::QW-1:0]  out_q
);
  import sbrc_pkg::*;

  logic [XW-1:0]   init_c;
  logic            zero_c, sat_c;

  logic            vld_r  [0:QB];
  sbrc_side_t      side_r [0:QB];
  logic [MW-1:0]   rem_r  [0:QB];
  logic [QB-1:0]   quo_r  [0:QB];
  logic [QB-1:0]   nlow_r [0:QB];
  logic [MW-1:0]   m4_r   [0:QB];
  logic            sat_r  [0:QB];
  logic            zero_r [0:QB];

  logic [MW:0]     t_c    [0:QB-1];
  logic [MW:0]     diff_c [0:QB-1];
  logic            ge_c   [0:QB-1];

  // Entry: the upper numerator bits decide saturation at four.
  always_comb begin
    init_c = XW'(in_r2[R2W-1:1]);
    zero_c = (in_m4 == '0);
    sat_c  = init_c >= XW'(in_m4);
  end

  // Trial subtraction of each stage.
  always_comb begin
    for (int i = 0; i < QB; i++) begin
      t_c[i]    = {rem_r[i], nlow_r[i][QB-1]};
      diff_c[i] = t_c[i] - {1'b0, m4_r[i]};
      ge_c[i]   = t_c[i] >= {1'b0, m4_r[i]};
    end
  end

  // Valid bits travel with each partial remainder.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= QB; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int i = 0; i < QB; i++) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
  end

  // Remainder, quotient and operand pipeline.
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= in_side;
      rem_r[0]  <= (zero_c || sat_c) ? '0 : init_c[MW-1:0];
      quo_r[0]  <= '0;
      nlow_r[0] <= {in_r2[0], {(QB-1){1'b0}}};
      m4_r[0]   <= in_m4;
      sat_r[0]  <= sat_c;
      zero_r[0] <= zero_c;
      for (int i = 0; i < QB; i++) begin
        side_r[i+1] <= side_r[i];
        rem_r[i+1]  <= ge_c[i] ? diff_c[i][MW-1:0] : t_c[i][MW-1:0];
        quo_r[i+1]  <= {quo_r[i][QB-2:0], ge_c[i]};
        nlow_r[i+1] <= nlow_r[i] << 1;
        m4_r[i+1]   <= m4_r[i];
        sat_r[i+1]  <= sat_r[i];
        zero_r[i+1] <= zero_r[i];
      end
    end
  end

  // A zero divisor gives zero; an oversized quotient clamps at four.
  always_comb begin
    if (zero_r[QB]) begin
      out_q = '0;
    end else if (sat_r[QB] || (quo_r[QB] > FX_QMAX)) begin
      out_q = FX_QMAX;
    end else begin
      out_q = quo_r[QB];
    end
  end

  assign out_vld  = vld_r[QB];
  assign out_side = side_r[QB];

endmodule

// ===== rtl/core/sbrc_scale.sv =====
// Back end: polynomial scale, scaled source coordinates, rounding and range checks.
module sbrc_scale (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_vld,
  input  sbrc_pkg::sbrc_side_t    in_side,
  input  logic [sbrc_pkg::QW-1:0] in_q,
  output logic                    out_vld,
  output sbrc_pkg::sbrc_out_t     out_res
);
  import sbrc_pkg::*;

  localparam int P22W = FRAC_BITS + QW;
  localparam int P24W = FRAC_BITS + Q2W;

  logic            a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r, f_vld_r;
  sbrc_side_t      a_side_r, b_side_r, c_side_r, d_side_r, e_side_r, f_side_r;

  logic [2*QW-1:0] a_qq_r;
  logic [P22W-1:0] a_p22_r;

  logic [2*QW-1:0] qqh_c;
  logic [P22W-1:0] p22h_c;
  logic [Q2W-1:0]  b_q2_r;
  logic [QW-1:0]   b_t22_r;

  logic [P24W-1:0] c_p24_r;
  logic [QW-1:0]   c_t22_r;

  logic [P24W-1:0] p24h_c;
  logic [SW-1:0]   d_s_r;

  logic signed [PRW-1:0] prx_c, pry_c;
  logic signed [PRW-1:0] e_prx_r, e_pry_r;

  logic [PW-1:0]   basex_c, basey_c;
  logic signed [PW-1:0] sumx_c, sumy_c;
  logic [NXW-1:0]  f_nx_r, f_ny_r;
  logic            f_negx_r, f_negy_r;

  logic            ok_c;

  // Valid bits of the six stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      f_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
      e_vld_r <= d_vld_r;
      f_vld_r <= e_vld_r;
    end
  end

  // Rounding adds and the scaled products.
  always_comb begin
    qqh_c   = a_qq_r + (2*QW)'(FX_HALF_I);
    p22h_c  = a_p22_r + P22W'(FX_HALF_I);
    p24h_c  = c_p24_r + P24W'(FX_HALF_I);
    prx_c   = $signed(d_side_r.dx) * $signed({1'b0, d_s_r});
    pry_c   = $signed(d_side_r.dy) * $signed({1'b0, d_s_r});
    // The centre has no fraction bits, so the rounding half is simply ORed in.
    basex_c = (PW'(e_side_r.xmid) << FRAC_BITS) | PW'(FX_HALF_I);
    basey_c = (PW'(e_side_r.ymid) << FRAC_BITS) | PW'(FX_HALF_I);
    sumx_c  = $signed({{(PW-PRW){e_prx_r[PRW-1]}}, e_prx_r}) + $signed(basex_c);
    sumy_c  = $signed({{(PW-PRW){e_pry_r[PRW-1]}}, e_pry_r}) + $signed(basey_c);
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage A: q squared and the linear term.
      a_side_r <= in_side;
      a_qq_r   <= in_q * in_q;
      a_p22_r  <= FX_C22 * in_q;

      // Stage B: round both to the fraction grid.
      b_side_r <= a_side_r;
      b_q2_r   <= qqh_c[FRAC_BITS +: Q2W];
      b_t22_r  <= p22h_c[FRAC_BITS +: QW];

      // Stage C: quadratic term.
      c_side_r <= b_side_r;
      c_p24_r  <= FX_C24 * b_q2_r;
      c_t22_r  <= b_t22_r;

      // Stage D: the scale factor.
      d_side_r <= c_side_r;
      d_s_r    <= FX_ONE + c_t22_r + p24h_c[FRAC_BITS +: QW];

      // Stage E: scaled offsets.
      e_side_r <= d_side_r;
      e_prx_r  <= prx_c;
      e_pry_r  <= pry_c;

      // Stage F: rounded source position; a sum below one half means the point folded negative.
      f_side_r <= e_side_r;
      f_nx_r   <= sumx_c[PW-1:FRAC_BITS];
      f_ny_r   <= sumy_c[PW-1:FRAC_BITS];
      f_negx_r <= sumx_c < $signed(PW'(FX_HALF_I));
      f_negy_r <= sumy_c < $signed(PW'(FX_HALF_I));
    end
  end

  // The source must stay in the pixel's own half and fit the coordinate field.
  always_comb begin
    ok_c = f_side_r.ok && !f_negx_r && !f_negy_r
        && (f_nx_r >= NXW'(f_side_r.start))
        && (f_nx_r <  NXW'(f_side_r.stop))
        && (f_ny_r <  NXW'(f_side_r.hgt))
        && (f_nx_r <= NXW'({COORD_BITS{1'b1}}))
        && (f_ny_r <= NXW'({COORD_BITS{1'b1}}));
    out_res.src_x      = ok_c ? f_nx_r[COORD_BITS-1:0] : '0;
    out_res.src_y      = ok_c ? f_ny_r[COORD_BITS-1:0] : '0;
    out_res.valid_res  = ok_c;
    out_res.fill_value = f_side_r.chroma ? FILL_CHROMA : FILL_LUMA;
  end

  assign out_vld = f_vld_r;

endmodule

// ===== rtl/core/stereo_barrel_remap_coordinates.sv =====
// Top level of the stereo barrel remap coordinate generator.
//
// Each input transfer on in_valid/in_stall carries one destination pixel
// (column, row, plane flag) of a side-by-side stereo frame. Each one yields
// exactly one output transfer on out_valid/out_stall with the source pixel to
// fetch, a flag telling whether it exists, and the fill level to use if not.
// The frame size is set through the cfg_we/cfg_index/cfg_wdata write port and
// must only change while the pipeline is empty.
//
// From the input transfer to out_valid a pixel passes four geometry stages,
// one entry stage plus one stage per quotient bit (FRAC_BITS + 3) in the
// radius divider, six scale stages and the output register. One pixel is
// taken every cycle while the pipeline is not stalled; the divider chain sets
// the depth. When the receiver stalls with a result waiting, the whole
// pipeline holds and in_stall rises in the same cycle, so nothing is lost or
// repeated. Reset empties the pipeline and restores the 1920 x 1080 size.
module stereo_barrel_remap_coordinates (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sbrc_pkg::sbrc_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sbrc_pkg::sbrc_out_t         out_data,
  input  logic                        cfg_we,
  input  logic [sbrc_pkg::CFG_AW-1:0] cfg_index,
  input  logic [sbrc_pkg::REG_W-1:0]  cfg_wdata
);
  import sbrc_pkg::*;

  logic             adv;
  logic [REG_W-1:0] frame_w_r, frame_h_r;

  logic             g_vld;
  sbrc_side_t       g_side;
  logic [R2W-1:0]   g_r2;
  logic [MW-1:0]    g_m4;

  logic             d_vld;
  sbrc_side_t       d_side;
  logic [QW-1:0]    d_q;

  logic             s_vld;
  sbrc_out_t        s_res;

  logic             out_valid_r;
  sbrc_out_t        out_data_r;

  // The pipeline moves whenever the output register is empty or being drained.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Frame size registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= FRAME_WIDTH_RST;
      frame_h_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_w_r <= cfg_wdata;
        CFG_FRAME_HEIGHT: frame_h_r <= cfg_wdata;
        default:          ;
      endcase
    end
  end

  sbrc_geom u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (in_valid),
    .in_data  (in_data),
    .frame_w  (frame_w_r),
    .frame_h  (frame_h_r),
    .out_vld  (g_vld),
    .out_side (g_side),
    .out_r2   (g_r2),
    .out_m4   (g_m4)
  );

  sbrc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_vld   (g_vld),
    .in_side  (g_side),
    .in_r2    (g_r2),
    .in_m4    (g_m4),
    .out_vld  (d_vld),
    .out_side (d_side),
    .out_q    (d_q)
  );

  sbrc_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (d_vld),
    .in_side (d_side),
    .in_q    (d_q),
    .out_vld (s_vld),
    .out_res (s_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= s_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
